@@ design/assert_macros.svh @@
// Assertion macros used by the checker file of the list manager.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define DLLM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define DLLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/dllm_pkg.sv @@
// Package of the doubly linked list manager: sizes, command codes, types, helpers.
// Depends on nothing; the RTL, checker and testbench files import it.
`default_nettype none

package dllm_pkg;

   localparam int NODE_SLOTS = 256;
   localparam int IDX_W      = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
   localparam int LINK_W     = $clog2(NODE_SLOTS + 1);
   localparam int CMD_W      = 3;
   localparam int TARGET_W   = 9;
   localparam int NEW_W      = 8;
   localparam int ELEM_W     = 9;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [LINK_W-1:0] link_type;

   localparam link_type NULL_LINK = LINK_W'(NODE_SLOTS);
   localparam idx_type  LAST_IDX  = IDX_W'(NODE_SLOTS - 1);

   localparam logic [CMD_W-1:0] CMD_ADD_FIRST  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_ADD_LAST   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_BEFORE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ADD_AFTER  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_UNLINK     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_GET_FIRST  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_GET_NEXT   = 3'd6;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LINK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [CMD_W-1:0]    command;
      logic [TARGET_W-1:0] target_node;
      logic [NEW_W-1:0]    new_node;
   } req_type;

   typedef struct packed {
      logic              ok;
      logic [ELEM_W-1:0] element;
   } rsp_type;

   typedef struct packed {
      logic     en;
      idx_type  addr;
      link_type data;
   } ram_wr_type;

   function automatic logic is_node(link_type l);
      return l < NULL_LINK;
   endfunction

   function automatic idx_type to_idx(link_type l);
      return l[IDX_W-1:0];
   endfunction

   function automatic link_type target_link(logic [TARGET_W-1:0] t);
      if (t < TARGET_W'(NODE_SLOTS)) return LINK_W'(t);
      return NULL_LINK;
   endfunction

   function automatic link_type new_link(logic [NEW_W-1:0] n);
      if (LINK_W'(n) < NULL_LINK) return LINK_W'(n);
      return NULL_LINK;
   endfunction

endpackage

`default_nettype wire

@@ design/dllm_link_ram.sv @@
// One link table: single write port, single read port with registered read data.
// Depends on dllm_pkg for the table depth and entry types.
`default_nettype none

module dllm_link_ram import dllm_pkg::*; (
   input  wire        clock,
   input  ram_wr_type wr,
   input  wire        rd_en,
   input  idx_type    rd_addr,
   output link_type   rd_data
);

   link_type mem [NODE_SLOTS];
   link_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ design/doubly_linked_list_manager_top.sv @@
// Top level of the doubly linked list manager: command sequencer, head, tail and cursor.
// Depends on dllm_pkg and two dllm_link_ram instances for the previous and next tables.
//
//   Channel | Ports         | Direction | Moves
//   req     | req_*         | in        | one command item
//   rsp     | rsp_*         | out       | one result item per command
//
// Each item is read, then written: the accept cycle reads both link tables at the target or
// cursor, then ST_LINK and ST_FINISH write each table through its single write port.
// After reset a clearing pass writes null to every slot before req_ready rises. An item
// finishes only when the result register is free; a new item is accepted while a
// finished result still waits to be taken.
`default_nettype none

module doubly_linked_list_manager_top import dllm_pkg::*; (
   input  wire     clock,
   input  wire     reset,
   input  wire     req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  wire     rsp_ready,
   output rsp_type rsp_payload
);

   state_type        state_ff, state_in;
   idx_type          clr_cnt_ff, clr_cnt_in;
   logic [CMD_W-1:0] cmd_ff, cmd_in;
   link_type         p_ff, p_in;
   link_type         q_ff, q_in;
   logic             ok_ff, ok_in;
   link_type         head_ff, head_in;
   link_type         tail_ff, tail_in;
   link_type         cursor_ff, cursor_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_payload_ff, rsp_payload_in;

   ram_wr_type prev_wr, next_wr;
   logic       rd_en;
   idx_type    rd_addr;
   link_type   prev_rd, next_rd;
   logic       accept, out_free;
   link_type   req_p, req_q;

   dllm_link_ram u_prev_ram (
      .clock   (clock),
      .wr      (prev_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (prev_rd)
   );

   dllm_link_ram u_next_ram (
      .clock   (clock),
      .wr      (next_wr),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (next_rd)
   );

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_p       = target_link(req_payload.target_node);
   assign req_q       = new_link(req_payload.new_node);
   assign rd_en       = accept;
   assign rd_addr     = (req_payload.command == CMD_GET_NEXT) ? to_idx(cursor_ff)
                                                              : to_idx(req_p);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         head_ff      <= NULL_LINK;
         tail_ff      <= NULL_LINK;
         cursor_ff    <= NULL_LINK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      p_ff           <= p_in;
      q_ff           <= q_in;
      ok_ff          <= ok_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   always_comb begin
      state_in       = state_ff;
      clr_cnt_in     = clr_cnt_ff;
      cmd_in         = cmd_ff;
      p_in           = p_ff;
      q_in           = q_ff;
      ok_in          = ok_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      cursor_in      = cursor_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_payload_in = rsp_payload_ff;
      prev_wr        = '{en: 1'b0, addr: to_idx(p_ff), data: NULL_LINK};
      next_wr        = '{en: 1'b0, addr: to_idx(p_ff), data: NULL_LINK};

      unique case (state_ff)
         ST_CLEAR: begin
            prev_wr    = '{en: 1'b1, addr: clr_cnt_ff, data: NULL_LINK};
            next_wr    = '{en: 1'b1, addr: clr_cnt_ff, data: NULL_LINK};
            clr_cnt_in = clr_cnt_ff + idx_type'(1);
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_payload.command;
               p_in     = req_p;
               q_in     = req_q;
               state_in = ST_LINK;
               case (req_payload.command) inside
                  CMD_ADD_FIRST, CMD_ADD_LAST, CMD_UNLINK: ok_in = is_node(req_p);
                  CMD_ADD_BEFORE, CMD_ADD_AFTER: ok_in = is_node(req_p) && is_node(req_q);
                  CMD_GET_FIRST, CMD_GET_NEXT: ok_in = 1'b1;
                  default: ok_in = 1'b0;
               endcase
            end
         end
         ST_LINK: begin
            state_in = ST_FINISH;
            if (ok_ff) begin
               case (cmd_ff)
                  CMD_ADD_FIRST: begin
                     prev_wr = '{en: 1'b1, addr: to_idx(p_ff), data: NULL_LINK};
                     next_wr = '{en: 1'b1, addr: to_idx(p_ff), data: head_ff};
                  end
                  CMD_ADD_LAST: begin
                     next_wr = '{en: 1'b1, addr: to_idx(p_ff), data: NULL_LINK};
                     prev_wr = '{en: 1'b1, addr: to_idx(p_ff), data: tail_ff};
                  end
                  CMD_ADD_BEFORE: begin
                     next_wr = '{en: is_node(prev_rd), addr: to_idx(prev_rd), data: q_ff};
                     prev_wr = '{en: 1'b1, addr: to_idx(q_ff), data: prev_rd};
                  end
                  CMD_ADD_AFTER: begin
                     prev_wr = '{en: is_node(next_rd), addr: to_idx(next_rd), data: q_ff};
                     next_wr = '{en: 1'b1, addr: to_idx(q_ff), data: next_rd};
                  end
                  CMD_UNLINK: begin
                     next_wr = '{en: is_node(prev_rd), addr: to_idx(prev_rd), data: next_rd};
                     prev_wr = '{en: is_node(next_rd), addr: to_idx(next_rd), data: prev_rd};
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in               = ST_IDLE;
               rsp_valid_in           = 1'b1;
               rsp_payload_in.ok      = ok_ff;
               rsp_payload_in.element = ELEM_W'(NULL_LINK);
               if (ok_ff) begin
                  case (cmd_ff)
                     CMD_ADD_FIRST: begin
                        prev_wr = '{en: is_node(head_ff), addr: to_idx(head_ff), data: p_ff};
                        if (!is_node(head_ff)) tail_in = p_ff;
                        head_in = p_ff;
                     end
                     CMD_ADD_LAST: begin
                        next_wr = '{en: is_node(tail_ff), addr: to_idx(tail_ff), data: p_ff};
                        if (!is_node(tail_ff)) head_in = p_ff;
                        tail_in = p_ff;
                     end
                     CMD_ADD_BEFORE: begin
                        next_wr = '{en: 1'b1, addr: to_idx(q_ff), data: p_ff};
                        prev_wr = '{en: 1'b1, addr: to_idx(p_ff), data: q_ff};
                        if (!is_node(prev_rd)) head_in = q_ff;
                     end
                     CMD_ADD_AFTER: begin
                        prev_wr = '{en: 1'b1, addr: to_idx(q_ff), data: p_ff};
                        next_wr = '{en: 1'b1, addr: to_idx(p_ff), data: q_ff};
                        if (!is_node(next_rd)) tail_in = q_ff;
                     end
                     CMD_UNLINK: begin
                        next_wr = '{en: 1'b1, addr: to_idx(p_ff), data: NULL_LINK};
                        prev_wr = '{en: 1'b1, addr: to_idx(p_ff), data: NULL_LINK};
                        if (!is_node(prev_rd)) head_in = next_rd;
                        if (!is_node(next_rd)) tail_in = prev_rd;
                     end
                     CMD_GET_FIRST: begin
                        cursor_in              = head_ff;
                        rsp_payload_in.element = ELEM_W'(head_ff);
                     end
                     CMD_GET_NEXT: begin
                        if (is_node(cursor_ff)) begin
                           cursor_in              = next_rd;
                           rsp_payload_in.element = ELEM_W'(next_rd);
                        end else begin
                           rsp_payload_in.element = ELEM_W'(cursor_ff);
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/dllm_checker.sv @@
// Port-level checker for the doubly linked list manager, bound to the top level.
// Depends on dllm_pkg and the assertion macros in assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module dllm_checker import dllm_pkg::*; (
   input wire     clock,
   input wire     reset,
   input wire     req_valid,
   input wire     req_ready,
   input wire     rsp_valid,
   input wire     rsp_ready,
   input rsp_type rsp_payload
);

   `DLLM_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "result item changed or dropped while stalled")
   `DLLM_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "block took a second item while one was in progress")
   `DLLM_ASSERT(a_refused_null, clock, reset, rsp_valid && !rsp_payload.ok |-> rsp_payload.element == ELEM_W'(NODE_SLOTS), "refused command returned a node")
   `DLLM_ASSERT(a_no_stray_rsp, clock, reset, rsp_valid && rsp_ready && req_ready |=> !rsp_valid, "result item appeared with no item in progress")
   `DLLM_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !req_ready && !rsp_valid, "block not quiet after reset")

endmodule

bind doubly_linked_list_manager_top dllm_checker u_dllm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for doubly_linked_list_manager_top: a directed table, then random
// list edits and cursor sweeps, checked against a link-table predictor held here or pinned results.
// Depends on dllm_pkg and the RTL of the list manager.
`timescale 1ns / 100ps

module testbench import dllm_pkg::*; ();

   localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam int RANDOM_PER_PACE = 238;
   localparam int MAX_CHAIN = 48;
   localparam int DRAIN_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int SENDER_IDLE_PCT [4] = '{0, 64, 0, 27};
   localparam int SINK_STALL_PCT [4] = '{0, 0, 64, 27};

   typedef struct packed {
      logic    pinned;
      rsp_type want;
   } typed_result_type;

   typedef struct packed {
      req_type item;
      logic    pinned;
      rsp_type want;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   link_type prev_of [NODE_SLOTS];
   link_type next_of [NODE_SLOTS];
   link_type head_of_list;
   link_type tail_of_list;
   link_type cursor_at;

   typed_result_type typed_result_q [$];
   rsp_type          expected_result_q [$];
   int               chain [$];
   bit               linked [NODE_SLOTS];
   directed_row_type directed_rows [26];

   int          sender_idle_pct = 0;
   int          sink_stall_pct = 0;
   int          random_sent = 0;
   int          error_count = 0;
   int unsigned cycle_count = 0;

   doubly_linked_list_manager_top DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #6 clock = ~clock;

   function automatic rsp_type apply_list_command(input req_type item);
      link_type anchor;
      link_type fresh;
      link_type nbr;
      rsp_type  result;
      anchor = (item.target_node < TARGET_W'(NODE_SLOTS)) ? link_type'(item.target_node)
                                                          : NULL_LINK;
      fresh = (LINK_W'(item.new_node) < NULL_LINK) ? link_type'(item.new_node) : NULL_LINK;
      result.ok = 1'b1;
      result.element = NULL_LINK;
      case (item.command)
         CMD_ADD_FIRST: begin
            if (anchor == NULL_LINK) begin
               result.ok = 1'b0;
            end else begin
               prev_of[to_idx(anchor)] = NULL_LINK;
               next_of[to_idx(anchor)] = head_of_list;
               if (head_of_list != NULL_LINK) prev_of[to_idx(head_of_list)] = anchor;
               else tail_of_list = anchor;
               head_of_list = anchor;
            end
         end
         CMD_ADD_LAST: begin
            if (anchor == NULL_LINK) begin
               result.ok = 1'b0;
            end else begin
               next_of[to_idx(anchor)] = NULL_LINK;
               prev_of[to_idx(anchor)] = tail_of_list;
               if (tail_of_list != NULL_LINK) next_of[to_idx(tail_of_list)] = anchor;
               else head_of_list = anchor;
               tail_of_list = anchor;
            end
         end
         CMD_ADD_BEFORE: begin
            if (anchor == NULL_LINK || fresh == NULL_LINK) begin
               result.ok = 1'b0;
            end else begin
               nbr = prev_of[to_idx(anchor)];
               if (nbr == NULL_LINK) head_of_list = fresh;
               else next_of[to_idx(nbr)] = fresh;
               prev_of[to_idx(fresh)] = prev_of[to_idx(anchor)];
               next_of[to_idx(fresh)] = anchor;
               prev_of[to_idx(anchor)] = fresh;
            end
         end
         CMD_ADD_AFTER: begin
            if (anchor == NULL_LINK || fresh == NULL_LINK) begin
               result.ok = 1'b0;
            end else begin
               nbr = next_of[to_idx(anchor)];
               if (nbr == NULL_LINK) tail_of_list = fresh;
               else prev_of[to_idx(nbr)] = fresh;
               next_of[to_idx(fresh)] = next_of[to_idx(anchor)];
               prev_of[to_idx(fresh)] = anchor;
               next_of[to_idx(anchor)] = fresh;
            end
         end
         CMD_UNLINK: begin
            if (anchor == NULL_LINK) begin
               result.ok = 1'b0;
            end else begin
               nbr = prev_of[to_idx(anchor)];
               if (nbr == NULL_LINK) head_of_list = next_of[to_idx(anchor)];
               else next_of[to_idx(nbr)] = next_of[to_idx(anchor)];
               nbr = next_of[to_idx(anchor)];
               if (nbr == NULL_LINK) tail_of_list = prev_of[to_idx(anchor)];
               else prev_of[to_idx(nbr)] = prev_of[to_idx(anchor)];
               prev_of[to_idx(anchor)] = NULL_LINK;
               next_of[to_idx(anchor)] = NULL_LINK;
            end
         end
         CMD_GET_FIRST: begin
            cursor_at = head_of_list;
            result.element = head_of_list;
         end
         CMD_GET_NEXT: begin
            if (cursor_at != NULL_LINK) cursor_at = next_of[to_idx(cursor_at)];
            result.element = cursor_at;
         end
         default: begin
            result.ok = 1'b0;
         end
      endcase
      return result;
   endfunction

   function automatic directed_row_type make_row(input logic [CMD_W-1:0] command,
                                                 input int target, input int fresh,
                                                 input logic pinned, input logic ok,
                                                 input link_type element);
      directed_row_type row;
      row.item.command = command;
      row.item.target_node = TARGET_W'(target);
      row.item.new_node = NEW_W'(fresh);
      row.pinned = pinned;
      row.want.ok = ok;
      row.want.element = element;
      return row;
   endfunction

   function automatic int pick_free_node();
      int node;
      do node = $urandom_range(NODE_SLOTS - 1); while (linked[idx_type'(node)]);
      return node;
   endfunction

   task automatic send_command(input req_type item, input logic pinned, input rsp_type want);
      typed_result_type typed;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      typed.pinned = pinned;
      typed.want = want;
      typed_result_q.push_back(typed);
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_checked(input req_type item);
      send_command(item, 1'b0, '0);
   endtask

   // Mostly well-formed edits of a shadow list, plus cursor sweeps and ignored commands.
   task automatic random_burst();
      req_type item;
      int      roll;
      int      pos;
      int      node;
      int      steps;
      roll = $urandom_range(99);
      item.command = CMD_GET_FIRST;
      item.target_node = TARGET_W'($urandom_range(511));
      item.new_node = NEW_W'($urandom_range(255));
      if (roll < 12) begin
         case ($urandom_range(3))
            0: begin
               item.command = CMD_W'($urandom_range(CMD_UNLINK));
               item.target_node = TARGET_W'($urandom_range(511, NODE_SLOTS));
            end
            1: item.command = CMD_UNUSED;
            2: item.command = CMD_GET_NEXT;
            default: begin
            end
         endcase
         send_checked(item);
         random_sent++;
      end else if (roll < 24) begin
         send_checked(item);
         steps = $urandom_range(chain.size() + 2, 1);
         item.command = CMD_GET_NEXT;
         repeat (steps) begin
            item.target_node = TARGET_W'($urandom_range(511));
            item.new_node = NEW_W'($urandom_range(255));
            send_checked(item);
         end
         random_sent += steps + 1;
      end else begin
         if (chain.size() == 0 || (chain.size() < MAX_CHAIN && $urandom_range(99) < 50)) begin
            node = pick_free_node();
            linked[idx_type'(node)] = 1'b1;
            case ((chain.size() == 0) ? $urandom_range(1) : $urandom_range(3))
               0: begin
                  item.command = CMD_ADD_FIRST;
                  item.target_node = TARGET_W'(node);
                  chain.push_front(node);
               end
               1: begin
                  item.command = CMD_ADD_LAST;
                  item.target_node = TARGET_W'(node);
                  chain.push_back(node);
               end
               2: begin
                  pos = $urandom_range(chain.size() - 1);
                  item.command = CMD_ADD_BEFORE;
                  item.target_node = TARGET_W'(chain[pos]);
                  item.new_node = NEW_W'(node);
                  chain.insert(pos, node);
               end
               default: begin
                  pos = $urandom_range(chain.size() - 1);
                  item.command = CMD_ADD_AFTER;
                  item.target_node = TARGET_W'(chain[pos]);
                  item.new_node = NEW_W'(node);
                  chain.insert(pos + 1, node);
               end
            endcase
         end else begin
            pos = $urandom_range(chain.size() - 1);
            item.command = CMD_UNLINK;
            item.target_node = TARGET_W'(chain[pos]);
            linked[idx_type'(chain[pos])] = 1'b0;
            chain.delete(pos);
         end
         send_checked(item);
         random_sent++;
      end
   endtask

   always @(posedge clock) begin : accept_monitor
      rsp_type          predicted;
      typed_result_type typed;
      if (!reset && req_valid && req_ready) begin
         predicted = apply_list_command(req_payload);
         typed = typed_result_q.pop_front();
         expected_result_q.push_back(typed.pinned ? typed.want : predicted);
      end
   end

   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_result_q.size() == 0) begin
            $error("Result item with no command outstanding: ok=%0d element=%0d",
                   rsp_payload.ok, rsp_payload.element);
            error_count = error_count + 1;
         end else begin
            want = expected_result_q.pop_front();
            if (rsp_payload.ok !== want.ok) begin
               $error("ok: expected %0d, actual %0d", want.ok, rsp_payload.ok);
               error_count = error_count + 1;
            end
            if (rsp_payload.element !== want.element) begin
               $error("element: expected %0d, actual %0d", want.element, rsp_payload.element);
               error_count = error_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= sink_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int pace;
      for (int n = 0; n < NODE_SLOTS; n++) begin
         prev_of[idx_type'(n)] = NULL_LINK;
         next_of[idx_type'(n)] = NULL_LINK;
         linked[idx_type'(n)] = 1'b0;
      end
      head_of_list = NULL_LINK;
      tail_of_list = NULL_LINK;
      cursor_at = NULL_LINK;

      // The table starts on an empty list and ends with the list empty again.
      directed_rows = '{
         make_row(CMD_GET_FIRST,  0,   0,   1'b1, 1'b1, NULL_LINK),
         make_row(CMD_GET_NEXT,   0,   0,   1'b1, 1'b1, NULL_LINK),
         make_row(CMD_UNLINK,     256, 0,   1'b1, 1'b0, NULL_LINK),
         make_row(CMD_UNLINK,     511, 255, 1'b1, 1'b0, NULL_LINK),
         make_row(CMD_ADD_FIRST,  256, 0,   1'b1, 1'b0, NULL_LINK),
         make_row(CMD_ADD_LAST,   300, 0,   1'b1, 1'b0, NULL_LINK),
         make_row(CMD_ADD_BEFORE, 257, 3,   1'b1, 1'b0, NULL_LINK),
         make_row(CMD_ADD_AFTER,  511, 255, 1'b1, 1'b0, NULL_LINK),
         make_row(CMD_UNUSED,     5,   5,   1'b1, 1'b0, NULL_LINK),
         make_row(CMD_ADD_FIRST,  0,   0,   1'b1, 1'b1, NULL_LINK),
         make_row(CMD_ADD_FIRST,  0,   0,   1'b0, 1'b0, NULL_LINK),
         make_row(CMD_ADD_AFTER,  0,   0,   1'b0, 1'b0, NULL_LINK),
         make_row(CMD_UNLINK,     0,   0,   1'b0, 1'b0, NULL_LINK),
         make_row(CMD_ADD_LAST,   255, 0,   1'b1, 1'b1, NULL_LINK),
         make_row(CMD_ADD_BEFORE, 255, 128, 1'b1, 1'b1, NULL_LINK),
         make_row(CMD_ADD_AFTER,  0,   1,   1'b1, 1'b1, NULL_LINK),
         make_row(CMD_ADD_AFTER,  255, 170, 1'b0, 1'b0, NULL_LINK),
         make_row(CMD_ADD_BEFORE, 0,   85,  1'b0, 1'b0, NULL_LINK),
         make_row(CMD_GET_FIRST,  511, 255, 1'b0, 1'b0, NULL_LINK),
         make_row(CMD_GET_NEXT,   0,   0,   1'b0, 1'b0, NULL_LINK),
         make_row(CMD_UNLINK,     0,   0,   1'b0, 1'b0, NULL_LINK),
         make_row(CMD_UNLINK,     85,  0,   1'b0, 1'b0, NULL_LINK),
         make_row(CMD_UNLINK,     170, 0,   1'b0, 1'b0, NULL_LINK),
         make_row(CMD_UNLINK,     1,   0,   1'b0, 1'b0, NULL_LINK),
         make_row(CMD_UNLINK,     128, 0,   1'b0, 1'b0, NULL_LINK),
         make_row(CMD_UNLINK,     255, 0,   1'b0, 1'b0, NULL_LINK)
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         send_command(directed_rows[r].item, directed_rows[r].pinned, directed_rows[r].want);
      end

      for (pace = 0; pace < 4; pace++) begin
         sender_idle_pct = SENDER_IDLE_PCT[pace];
         sink_stall_pct = SINK_STALL_PCT[pace];
         random_sent = 0;
         while (random_sent < RANDOM_PER_PACE) random_burst();
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (expected_result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
